// ===== rtl/job_queue_with_cancel_unit_defines.svh =====
// Assertion macros shared by the job queue RTL.
`ifndef JOB_QUEUE_WITH_CANCEL_UNIT_DEFINES_SVH
`define JOB_QUEUE_WITH_CANCEL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define JQC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("job queue assertion failed");
`define JQC_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("job queue assertion failed");
`else
`define JQC_ASSERT(label, prop)
`define JQC_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/jqc_pkg.sv =====
// Types, constants and index helpers for the job queue.
`default_nettype none

package jqc_pkg;

   localparam int DEPTH    = 16;
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TAG_W    = 32;
   localparam int PAGE_W   = 10;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 4;
   localparam int ACT_W    = 2;

   localparam logic [PAGE_W-1:0] PAGE_LIMIT_RESET = PAGE_W'(50);

   typedef enum logic [ACT_W-1:0] {
      ACT_ENQUEUE = 2'd0,
      ACT_DEQUEUE = 2'd1,
      ACT_CANCEL  = 2'd2,
      ACT_CLEAR   = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_PAGES = 3'd1,
      ST_FULL  = 3'd2,
      ST_EMPTY = 3'd3,
      ST_NOTAG = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEQ,
      S_SCAN,
      S_SHIFT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [PAGE_W-1:0] pages;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic [IDX_W-1:0] raddr;
   } ram_req_type;

   typedef struct packed {
      status_type        status;
      logic [TAG_W-1:0]  tag;
      logic [PAGE_W-1:0] pages;
      logic [OCC_W-1:0]  occupancy;
   } result_type;

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
   endfunction

   // Entries held, (tail - head) mod DEPTH, reported in OCC_W bits.
   function automatic logic [OCC_W-1:0] occupancy(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] tail);
      logic [IDX_W:0] diff;
      if (tail >= head) begin
         diff = {1'b0, tail} - {1'b0, head};
      end else begin
         diff = {1'b0, tail} + (IDX_W+1)'(DEPTH) - {1'b0, head};
      end
      return OCC_W'(diff);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/jqc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module jqc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/jqc_ctrl.sv =====
// Queue sequencer: pointers, page limit, and the scan and shift walk for cancel.
`default_nettype none

module jqc_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire jqc_pkg::action_type           req_action,
   input  wire logic [jqc_pkg::TAG_W-1:0]     req_tag,
   input  wire logic [jqc_pkg::PAGE_W-1:0]    req_pages,
   input  wire logic                          csr_wr_en,
   input  wire logic [jqc_pkg::PAGE_W-1:0]    csr_wr_data,
   output jqc_pkg::ram_req_type               ram,
   input  wire jqc_pkg::entry_type            ram_rd_data,
   output jqc_pkg::result_type                res,
   output logic                               res_valid,
   input  wire logic                          res_taken
);

   jqc_pkg::state_type            state_ff, state_in;
   logic [jqc_pkg::IDX_W-1:0]     head_ff, head_in;
   logic [jqc_pkg::IDX_W-1:0]     tail_ff, tail_in;
   logic [jqc_pkg::IDX_W-1:0]     ptr_ff, ptr_in;
   logic [jqc_pkg::IDX_W-1:0]     dst_ff, dst_in;
   logic                          pend_ff, pend_in;
   logic [jqc_pkg::TAG_W-1:0]     key_ff, key_in;
   jqc_pkg::status_type           status_ff, status_in;
   logic [jqc_pkg::TAG_W-1:0]     tag_out_ff, tag_out_in;
   logic [jqc_pkg::PAGE_W-1:0]    pages_out_ff, pages_out_in;
   logic [jqc_pkg::PAGE_W-1:0]    limit_ff, limit_in;

   logic empty;
   logic full;
   logic too_many;
   logic issue;
   logic hit;
   logic walk_done;

   assign empty     = (head_ff == tail_ff);
   assign full      = (jqc_pkg::idx_next(tail_ff) == head_ff);
   assign too_many  = (req_pages > limit_ff);
   assign issue     = (ptr_ff != tail_ff);
   // The one comparator: checks the entry read in the previous cycle.
   assign hit       = pend_ff && (ram_rd_data.tag == key_ff);
   assign walk_done = !pend_ff && !issue;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jqc_pkg::S_IDLE: begin
            if (req_valid) begin
               unique case (req_action)
                  jqc_pkg::ACT_DEQUEUE: begin
                     state_in = empty ? jqc_pkg::S_FINISH : jqc_pkg::S_DEQ;
                  end
                  jqc_pkg::ACT_CANCEL: begin
                     state_in = empty ? jqc_pkg::S_FINISH : jqc_pkg::S_SCAN;
                  end
                  default: begin
                     state_in = jqc_pkg::S_FINISH;
                  end
               endcase
            end
         end
         jqc_pkg::S_DEQ: begin
            state_in = jqc_pkg::S_FINISH;
         end
         jqc_pkg::S_SCAN: begin
            if (hit) begin
               state_in = jqc_pkg::S_SHIFT;
            end else if (walk_done) begin
               state_in = jqc_pkg::S_FINISH;
            end
         end
         jqc_pkg::S_SHIFT: begin
            if (walk_done) begin
               state_in = jqc_pkg::S_FINISH;
            end
         end
         jqc_pkg::S_FINISH: begin
            if (res_taken) begin
               state_in = jqc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = jqc_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      ptr_in       = ptr_ff;
      dst_in       = dst_ff;
      pend_in      = pend_ff;
      key_in       = key_ff;
      status_in    = status_ff;
      tag_out_in   = tag_out_ff;
      pages_out_in = pages_out_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      ram.we       = 1'b0;
      ram.waddr    = tail_ff;
      ram.wdata    = '{pages: req_pages, tag: req_tag};
      ram.raddr    = head_ff;

      unique case (state_ff)
         jqc_pkg::S_IDLE: begin
            if (req_valid) begin
               status_in    = jqc_pkg::ST_OK;
               tag_out_in   = '0;
               pages_out_in = '0;
               key_in       = req_tag;
               pend_in      = 1'b0;
               ptr_in       = head_ff;
               unique case (req_action)
                  jqc_pkg::ACT_ENQUEUE: begin
                     if (too_many) begin
                        status_in = jqc_pkg::ST_PAGES;
                     end else if (full) begin
                        status_in = jqc_pkg::ST_FULL;
                     end else begin
                        ram.we  = 1'b1;
                        tail_in = jqc_pkg::idx_next(tail_ff);
                     end
                  end
                  jqc_pkg::ACT_DEQUEUE, jqc_pkg::ACT_CANCEL: begin
                     if (empty) begin
                        status_in = jqc_pkg::ST_EMPTY;
                     end
                  end
                  jqc_pkg::ACT_CLEAR: begin
                     head_in = '0;
                     tail_in = '0;
                  end
                  default: begin
                     status_in = jqc_pkg::ST_OK;
                  end
               endcase
            end
         end
         jqc_pkg::S_DEQ: begin
            tag_out_in   = ram_rd_data.tag;
            pages_out_in = ram_rd_data.pages;
            head_in      = jqc_pkg::idx_next(head_ff);
         end
         jqc_pkg::S_SCAN: begin
            // One read issued per cycle; dst_ff names the entry now on the read port.
            ram.raddr = ptr_ff;
            pend_in   = issue;
            dst_in    = ptr_ff;
            if (issue) begin
               ptr_in = jqc_pkg::idx_next(ptr_ff);
            end
            if (hit) begin
               dst_in  = dst_ff;
               ptr_in  = jqc_pkg::idx_next(dst_ff);
               pend_in = 1'b0;
            end else if (walk_done) begin
               status_in = jqc_pkg::ST_NOTAG;
            end
         end
         jqc_pkg::S_SHIFT: begin
            // Each entry read one cycle is written one slot nearer the head the next.
            ram.raddr = ptr_ff;
            ram.waddr = dst_ff;
            ram.wdata = ram_rd_data;
            pend_in   = issue;
            if (issue) begin
               ptr_in = jqc_pkg::idx_next(ptr_ff);
            end
            if (pend_ff) begin
               ram.we = 1'b1;
               dst_in = jqc_pkg::idx_next(dst_ff);
            end
            if (walk_done) begin
               tail_in = jqc_pkg::idx_prev(tail_ff);
            end
         end
         jqc_pkg::S_FINISH: begin
            pend_in = 1'b0;
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jqc_pkg::S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         pend_ff  <= 1'b0;
         limit_ff <= jqc_pkg::PAGE_LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         pend_ff  <= pend_in;
         limit_ff <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      dst_ff       <= dst_in;
      key_ff       <= key_in;
      status_ff    <= status_in;
      tag_out_ff   <= tag_out_in;
      pages_out_ff <= pages_out_in;
   end

   assign req_ready     = (state_ff == jqc_pkg::S_IDLE);
   assign res_valid     = (state_ff == jqc_pkg::S_FINISH);
   assign res.status    = status_ff;
   assign res.tag       = tag_out_ff;
   assign res.pages     = pages_out_ff;
   assign res.occupancy = jqc_pkg::occupancy(head_ff, tail_ff);

endmodule

`default_nettype wire

// ===== rtl/job_queue_with_cancel_unit.sv =====
// Enqueue, clear and refused operations go straight from idle to the finish state, a dequeue
// passes through the dequeue state first; a cancel walks the held entries with one RAM read per
// cycle until the tag is found, then shifts the later ones with one read and one write per
// cycle. One transaction is worked on at a time: the next is accepted only once the result
// of the previous one has been taken into the output register.
// Synchronous reset empties the queue and sets the page limit to 50; RAM is not cleared.
`default_nettype none

`include "job_queue_with_cancel_unit_defines.svh"

module job_queue_with_cancel_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [47:0]                  req_tdata,  // job_tag, page_count, zero pad
   input  wire logic [jqc_pkg::ACT_W-1:0]    req_tuser,  // action
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [47:0]                  rsp_tdata,  // tag_out, pages_out, occupancy, pad
   output logic      [jqc_pkg::STATUS_W-1:0] rsp_tuser,  // status
   input  wire logic                         csr_wr_en,
   input  wire logic [jqc_pkg::PAGE_W-1:0]   csr_wr_data
);

   jqc_pkg::ram_req_type ram;
   jqc_pkg::entry_type   ram_rd_data;
   jqc_pkg::result_type  res;
   logic                 res_valid;
   logic                 res_load;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   jqc_pkg::result_type  rsp_data_ff;

   jqc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_action  (jqc_pkg::action_type'(req_tuser)),
      .req_tag     (req_tdata[jqc_pkg::TAG_W-1:0]),
      .req_pages   (req_tdata[jqc_pkg::TAG_W +: jqc_pkg::PAGE_W]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ram         (ram),
      .ram_rd_data (ram_rd_data),
      .res         (res),
      .res_valid   (res_valid),
      .res_taken   (res_load)
   );

   jqc_ram #(
      .WIDTH (jqc_pkg::ENTRY_W),
      .DEPTH (jqc_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram.we),
      .wr_addr (ram.waddr),
      .wr_data (ram.wdata),
      .rd_addr (ram.raddr),
      .rd_data (ram_rd_data)
   );

   // The output register takes a new result whenever it is empty or being drained.
   assign res_load      = res_valid && (!rsp_tvalid_ff || rsp_tready);
   assign rsp_tvalid_in = res_load || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {2'b00, rsp_data_ff.occupancy, rsp_data_ff.pages, rsp_data_ff.tag};

   // A transaction accepted leaves the sequencer busy in the next cycle.
   `JQC_ASSERT(busy_after_accept, (req_tvalid && req_tready) |=> !req_tready)
   // A result is never handed over while a new transaction is being taken.
   `JQC_ASSERT(no_load_while_ready, res_load |-> !req_tready)
   // A stalled result in the output register is never overwritten.
   `JQC_ASSERT(no_overwrite, (rsp_tvalid_ff && !rsp_tready) |-> !res_load)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the job queue with cancel by tag, with its own queue predictor.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import jqc_pkg::*;

   // Tracks the queue contents and holds the results the block still owes.
   class job_queue_scoreboard;
      logic [TAG_W-1:0]  tag_slots[DEPTH];
      logic [PAGE_W-1:0] page_slots[DEPTH];
      int                head;
      int                tail;
      logic [PAGE_W-1:0] page_limit;
      result_type        awaited_results[$];
      int                mismatches;
      int                checked;
      int                status_count[5];

      function new();
         for (int i = 0; i < DEPTH; i++) begin
            tag_slots[i]  = '0;
            page_slots[i] = '0;
         end
         head       = 0;
         tail       = 0;
         page_limit = PAGE_LIMIT_RESET;
         mismatches = 0;
         checked    = 0;
         for (int i = 0; i < 5; i++) begin
            status_count[i] = 0;
         end
      endfunction

      function void set_page_limit(logic [PAGE_W-1:0] value);
         page_limit = value;
      endfunction

      function void note_request(action_type act, logic [TAG_W-1:0] tag,
                                 logic [PAGE_W-1:0] pages);
         result_type expected;
         bit         was_empty;
         bit         hit;
         int         idx;
         int         nxt;
         was_empty          = (head == tail);
         expected.status    = ST_OK;
         expected.tag       = '0;
         expected.pages     = '0;
         case (act)
            ACT_ENQUEUE: begin
               // The page check wins over the full check.
               if (pages > page_limit) begin
                  expected.status = ST_PAGES;
               end else if ((tail + 1) % DEPTH == head) begin
                  expected.status = ST_FULL;
               end else begin
                  tag_slots[tail]  = tag;
                  page_slots[tail] = pages;
                  tail             = (tail + 1) % DEPTH;
               end
            end
            ACT_DEQUEUE: begin
               if (was_empty) begin
                  expected.status = ST_EMPTY;
               end else begin
                  expected.tag   = tag_slots[head];
                  expected.pages = page_slots[head];
                  head           = (head + 1) % DEPTH;
               end
            end
            ACT_CANCEL: begin
               if (was_empty) begin
                  expected.status = ST_EMPTY;
               end else begin
                  idx = head;
                  hit = 1'b0;
                  while (idx != tail) begin
                     if (tag_slots[idx] == tag) begin
                        hit = 1'b1;
                        break;
                     end
                     idx = (idx + 1) % DEPTH;
                  end
                  if (!hit) begin
                     expected.status = ST_NOTAG;
                  end else begin
                     // Close the gap by pulling every later entry one slot forward.
                     nxt = (idx + 1) % DEPTH;
                     while (nxt != tail) begin
                        tag_slots[idx]  = tag_slots[nxt];
                        page_slots[idx] = page_slots[nxt];
                        idx             = nxt;
                        nxt             = (idx + 1) % DEPTH;
                     end
                     tail = (tail + DEPTH - 1) % DEPTH;
                  end
               end
            end
            default: begin
               head = 0;
               tail = 0;
            end
         endcase
         expected.occupancy = OCC_W'((tail + DEPTH - head) % DEPTH);
         awaited_results.push_back(expected);
      endfunction

      function void check_result(logic [STATUS_W-1:0] status, logic [TAG_W-1:0] tag,
                                 logic [PAGE_W-1:0] pages, logic [OCC_W-1:0] occ);
         result_type expected;
         if (awaited_results.size() == 0) begin
            $error("result transaction arrived with no job waiting for it");
            mismatches++;
            return;
         end
         expected = awaited_results.pop_front();
         checked++;
         if (int'(expected.status) < 5) begin
            status_count[int'(expected.status)]++;
         end
         if (status !== expected.status) begin
            $error("status: expected %0d, got %0d", expected.status, status);
            mismatches++;
         end
         if (tag !== expected.tag) begin
            $error("tag_out: expected %h, got %h", expected.tag, tag);
            mismatches++;
         end
         if (pages !== expected.pages) begin
            $error("pages_out: expected %0d, got %0d", expected.pages, pages);
            mismatches++;
         end
         if (occ !== expected.occupancy) begin
            $error("occupancy: expected %0d, got %0d", expected.occupancy, occ);
            mismatches++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [47:0]         req_tdata;  // job_tag, page_count, zero pad
   logic [ACT_W-1:0]    req_tuser;  // action
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [47:0]         rsp_tdata;  // tag_out, pages_out, occupancy, pad
   logic [STATUS_W-1:0] rsp_tuser;  // status
   logic                csr_wr_en;
   logic [PAGE_W-1:0]   csr_wr_data;

   job_queue_scoreboard queue_model = new();

   int idle_pct      = 0;
   int jobs_sent     = 0;
   int settings_used = 1;
   int long_holds    = 0;

   job_queue_with_cancel_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // A small pool of tags makes cancels hit and duplicates common.
   function automatic logic [TAG_W-1:0] pick_tag();
      if ($urandom_range(0, 3) == 0) begin
         return $urandom();
      end
      return 32'hC0DE_0000 | 32'($urandom_range(0, 7));
   endfunction

   task automatic send_job(action_type act, logic [TAG_W-1:0] tag, logic [PAGE_W-1:0] pages);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {6'b0, pages, tag};
      do begin
         @(posedge clock);
      end while (req_tready !== 1'b1);
      queue_model.note_request(act, tag, pages);
      jobs_sent++;
      gap = ($urandom_range(0, 99) < idle_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // The limit is only changed once the queue has answered everything it accepted.
   task automatic set_page_limit(logic [PAGE_W-1:0] value);
      req_tvalid <= 1'b0;
      while (queue_model.awaited_results.size() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      queue_model.set_page_limit(value);
      settings_used++;
   endtask

   task automatic send_random_job(int enq_pct);
      action_type        act;
      logic [PAGE_W-1:0] pages;
      int                pick;
      if ($urandom_range(0, 99) < enq_pct) begin
         act = ACT_ENQUEUE;
         if ($urandom_range(0, 99) < 85) begin
            pages = PAGE_W'($urandom_range(0, int'(queue_model.page_limit)));
         end else begin
            pages = PAGE_W'($urandom_range(0, 1023));
         end
      end else begin
         pick  = $urandom_range(0, 19);
         pages = PAGE_W'($urandom_range(0, 1023));
         if (pick == 0) begin
            act = ACT_CLEAR;
         end else if (pick < 8) begin
            act = ACT_CANCEL;
         end else begin
            act = ACT_DEQUEUE;
         end
      end
      send_job(act, pick_tag(), pages);
   endtask

   // Result side: random stalls, plus two long hold-offs that back the block up.
   initial begin : result_side
      int stall_left;
      int hold_left;
      int results_seen;
      stall_left   = 0;
      hold_left    = 0;
      results_seen = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            queue_model.check_result(rsp_tuser, rsp_tdata[31:0], rsp_tdata[41:32],
                                     rsp_tdata[45:42]);
            results_seen++;
            if (results_seen == 150 || results_seen == 420) begin
               hold_left = 300;
               long_holds++;
            end
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            stall_left = pick_gap() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   initial begin : stimulus
      logic [PAGE_W-1:0] phase_limit[6];
      int                phase_idle[6];
      int                phase_enq[6];
      phase_limit = '{10'd1023, 10'd0, 10'd0, 10'd1023, 10'd1, 10'd0};
      phase_idle  = '{30, 20, 40, 0, 25, 35};
      phase_enq   = '{70, 55, 40, 80, 60, 50};
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= ACT_ENQUEUE;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, under the reset page limit of 50.
      send_job(ACT_DEQUEUE, 32'h0, 10'd0);
      send_job(ACT_CANCEL, 32'hFFFF_FFFF, 10'd0);
      send_job(ACT_ENQUEUE, 32'hFFFF_FFFF, 10'd50);
      send_job(ACT_ENQUEUE, 32'h0, 10'd0);
      send_job(ACT_ENQUEUE, 32'h1234_5678, 10'd51);
      send_job(ACT_ENQUEUE, 32'h0, 10'd7);
      send_job(ACT_CANCEL, 32'hDEAD_BEEF, 10'd0);
      send_job(ACT_CANCEL, 32'h0, 10'h3FF);
      send_job(ACT_DEQUEUE, 32'hFFFF_FFFF, 10'h3FF);
      send_job(ACT_CLEAR, 32'hFFFF_FFFF, 10'h3FF);
      for (int i = 0; i < DEPTH - 1; i++) begin
         send_job(ACT_ENQUEUE, 32'h1000_0000 + 32'(i), PAGE_W'(i));
      end
      send_job(ACT_ENQUEUE, 32'h2000_0000, 10'd0);
      send_job(ACT_ENQUEUE, 32'h2000_0001, 10'h3FF);
      send_job(ACT_CANCEL, 32'h1000_000E, 10'd0);
      send_job(ACT_CANCEL, 32'h1000_0000, 10'd0);

      // Random part in phases, each under its own page limit and idling.
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 2 || phase == 5) begin
            phase_limit[phase] = PAGE_W'($urandom_range(2, 1022));
         end
         set_page_limit(phase_limit[phase]);
         idle_pct = phase_idle[phase];
         repeat (100) send_random_job(phase_enq[phase]);
      end

      req_tvalid <= 1'b0;
      while (queue_model.awaited_results.size() != 0) @(posedge clock);
      repeat (DEPTH + 10) @(posedge clock);

      $display("Sent %0d jobs under %0d page-limit settings, with %0d long result hold-offs.",
               jobs_sent, settings_used, long_holds);
      $display("Checked %0d results: ok %0d, over limit %0d, full %0d, empty %0d, no tag %0d.",
               queue_model.checked, queue_model.status_count[0], queue_model.status_count[1],
               queue_model.status_count[2], queue_model.status_count[3],
               queue_model.status_count[4]);
      if (queue_model.mismatches == 0 && queue_model.awaited_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/jqc_pkg.sv
rtl/jqc_ram.sv
rtl/jqc_ctrl.sv
rtl/job_queue_with_cancel_unit.sv
tb/tb_top.sv
